[rtl/tdp_pkg.sv]
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared types and constants for the trial-division prime test.
// ----------------------------------------------------------------------------
package tdp_pkg;

    // Width of the candidate port
    localparam int CAND_WIDTH = 32;

    // Status returned by the shared divider to the sequencer
    typedef struct packed {
        logic busy;   // division in progress
        logic done;   // one-cycle pulse: quotient and remainder valid
    } div_status_t;

endpackage

[rtl/trial_division_prime_test.sv]
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by trial division with divisors 2, 3, 4, ... while
// divisor * divisor <= number, on one shared iterative divider.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------
//   input   | in_valid / in_ready | candidate [31:0]
//   output  | out_valid/out_ready | is_prime
//
// Each divisor costs one division on the divider plus sequencing; 0 and 1
// skip the divider and are reported composite. The divider produces one
// quotient bit per cycle. in_ready is high only while the sequencer idles.
// A result waits in the output register; the next transaction is accepted
// meanwhile. Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module trial_division_prime_test
    import tdp_pkg::*;
#(
    parameter int NUM_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CAND_WIDTH-1:0] candidate,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  is_prime
);

    localparam int LOW_W = (NUM_WIDTH < CAND_WIDTH) ? NUM_WIDTH : CAND_WIDTH;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_HOLD
    } state_t;

    state_t               state_reg, state_next;
    logic [NUM_WIDTH-1:0] num_reg,   num_next;
    logic [NUM_WIDTH-1:0] dsr_reg,   dsr_next;
    logic                 res_reg,   res_next;
    logic                 start_reg, start_next;
    logic                 oval_reg,  oval_next;
    logic                 prime_reg, prime_next;

    logic [NUM_WIDTH-1:0] n_in;
    logic [NUM_WIDTH-1:0] quotient;
    logic [NUM_WIDTH-1:0] remainder;
    div_status_t          div_status;

    tdp_divider #(
        .WIDTH (NUM_WIDTH)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start_reg),
        .dividend  (num_reg),
        .divisor   (dsr_reg),
        .quotient  (quotient),
        .remainder (remainder),
        .status    (div_status)
    );

    assign n_in     = NUM_WIDTH'(candidate[LOW_W-1:0]);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        num_next   = num_reg;
        dsr_next   = dsr_reg;
        res_next   = res_reg;
        start_next = 1'b0;
        oval_next  = oval_reg;
        prime_next = prime_reg;

        // drop the result once taken
        if (oval_reg && out_ready)
        begin
            oval_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    num_next = n_in;
                    dsr_next = NUM_WIDTH'(2);
                    if (n_in <= NUM_WIDTH'(1))
                    begin
                        res_next   = 1'b0;
                        state_next = S_HOLD;
                    end
                    else
                    begin
                        start_next = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_status.done)
                begin
                    // divisor past n / divisor: no factor left below the root
                    if (dsr_reg > quotient)
                    begin
                        res_next   = 1'b1;
                        state_next = S_HOLD;
                    end
                    else if (remainder == '0)
                    begin
                        res_next   = 1'b0;
                        state_next = S_HOLD;
                    end
                    else
                    begin
                        dsr_next   = dsr_reg + NUM_WIDTH'(1);
                        start_next = 1'b1;
                    end
                end
            end
            S_HOLD:
            begin
                if (!oval_reg || out_ready)
                begin
                    oval_next  = 1'b1;
                    prime_next = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            num_reg   <= '0;
            dsr_reg   <= '0;
            res_reg   <= 1'b0;
            start_reg <= 1'b0;
            oval_reg  <= 1'b0;
            prime_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            num_reg   <= num_next;
            dsr_reg   <= dsr_next;
            res_reg   <= res_next;
            start_reg <= start_next;
            oval_reg  <= oval_next;
            prime_reg <= prime_next;
        end
    end

    assign out_valid = oval_reg;
    assign is_prime  = prime_reg;

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !div_status.busy && !div_status.done)
        else $error("divider active while sequencer idles");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> state_reg == S_DIV)
        else $error("division finished outside the divide state");

    a_divisor_min: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> dsr_reg >= NUM_WIDTH'(2))
        else $error("trial divisor below two");

    a_small_not_prime: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && n_in <= NUM_WIDTH'(1)
        |=> state_reg == S_HOLD && !res_reg)
        else $error("zero or one not reported as composite");

endmodule

[rtl/tdp_divider.sv]
// ----------------------------------------------------------------------------
// tdp_divider
// Restoring radix-2 divider, one quotient bit per cycle, shared across all
// trial divisors. Results stay valid until the next start.
// ----------------------------------------------------------------------------
module tdp_divider
    import tdp_pkg::*;
#(
    parameter int WIDTH = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder,
    output div_status_t      status
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH:0]   rem_reg,  rem_next;
    logic [WIDTH-1:0] quo_reg,  quo_next;
    logic [WIDTH-1:0] dsr_reg,  dsr_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [WIDTH:0]   trial;
    logic [WIDTH:0]   diff;
    logic             fits;

    always_comb
    begin
        trial     = {rem_reg[WIDTH-1:0], quo_reg[WIDTH-1]};
        diff      = trial - {1'b0, dsr_reg};
        fits      = (trial >= {1'b0, dsr_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            rem_next = fits ? diff : trial;
            quo_next = {quo_reg[WIDTH-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dsr_reg  <= dsr_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient    = quo_reg;
    assign remainder   = rem_reg[WIDTH-1:0];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[tb/trial_division_prime_test_tb.sv]
// ----------------------------------------------------------------------------
// trial_division_prime_test_tb
// Self-checking bench for the trial-division prime test. Each candidate
// goes through its own trial division in the bench, and the verdict is
// queued when the block accepts the candidate. Every result the block
// returns is checked against the oldest queued verdict.
// Stimulus, in order:
//   - directed edge values: 0..3, exact squares, word extremes, and the
//     largest 32-bit prime, which is the slowest run the block has
//   - a gap-free stream of small numbers
//   - small and medium numbers with random gaps and output stalls
//   - full-width words. Those with no small factor are made even, so
//     each test stays short.
// ----------------------------------------------------------------------------
module trial_division_prime_test_tb;
    import tdp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_WIDTH = 32;
    // most trial divisors a random full-width candidate is allowed to cost
    localparam int unsigned WIDE_DIV_BUDGET = 400;
    localparam int unsigned DRAIN_CYCLES = 100;

    typedef struct packed {
        logic [CAND_WIDTH-1:0] candidate;
        logic                  verdict;
    } verdict_t;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [CAND_WIDTH-1:0] candidate;
    logic                  out_valid;
    logic                  out_ready;
    logic                  is_prime;

    verdict_t    pending_verdicts[$];
    int unsigned error_count;
    bit          no_gaps;

    trial_division_prime_test #(
        .NUM_WIDTH (NUM_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .candidate (candidate),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .is_prime  (is_prime)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Trial division on the low NUM_WIDTH bits; also count the divisors tried
    function automatic bit trial_divide(input logic [CAND_WIDTH-1:0] n,
                                        output int unsigned divisions);
        longint unsigned num;
        longint unsigned d;
        num = 64'(n);
        if (NUM_WIDTH < 64)
            num = num & ((64'd1 << NUM_WIDTH) - 64'd1);
        divisions = 0;
        if (num <= 64'd1)
            return 1'b0;
        for (d = 64'd2; d <= num / d; d++)
        begin
            divisions++;
            if (num % d == 64'd0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Start and end at a falling edge; hold the transaction until accepted
    task automatic send_candidate(input logic [CAND_WIDTH-1:0] n);
        verdict_t    entry;
        int unsigned divisions;
        entry.candidate = n;
        entry.verdict   = trial_divide(n, divisions);
        if (!no_gaps && $urandom_range(0, 99) < 10)
            repeat ($urandom_range(1, 6)) @(negedge clk);
        in_valid  = 1'b1;
        candidate = n;
        do
            @(posedge clk);
        while (!in_ready);
        pending_verdicts.push_back(entry);
        @(negedge clk);
        in_valid  = 1'b0;
        candidate = $urandom();
    endtask

    // Output stalls: about one cycle in ten, none while no_gaps is set
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= no_gaps || ($urandom_range(0, 99) >= 10);
    end

    always @(posedge clk)
    begin
        verdict_t entry;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected result is_prime=%0b, expected none",
                         $realtime, is_prime);
                error_count++;
            end
            else
            begin
                entry = pending_verdicts.pop_front();
                if (is_prime !== entry.verdict)
                begin
                    $display("%0t: candidate %0d is_prime expected %0b actual %0b",
                             $realtime, entry.candidate, entry.verdict, is_prime);
                    error_count++;
                end
            end
        end
    end

    task automatic run_directed_edges();
        logic [CAND_WIDTH-1:0] edges[$];
        edges = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25,
                  32'd49, 32'd121, 32'd97, 32'd65521, 32'd65536,
                  32'hFFFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'd4294836225, 32'd4294967291};
        foreach (edges[i])
            send_candidate(edges[i]);
    endtask

    task automatic run_steady_stream(input int unsigned count);
        no_gaps = 1'b1;
        repeat (count)
            send_candidate($urandom_range(0, 4096));
        no_gaps = 1'b0;
    endtask

    task automatic run_gapped_small(input int unsigned count);
        repeat (count)
            send_candidate($urandom_range(0, 65535));
    endtask

    // Half are plain random, half are moved up to the next prime
    task automatic run_medium_numbers(input int unsigned count);
        logic [CAND_WIDTH-1:0] n;
        int unsigned           divisions;
        repeat (count)
        begin
            n = $urandom_range(65536, 262143);
            if ($urandom_range(0, 1))
                while (!trial_divide(n, divisions))
                    n++;
            send_candidate(n);
        end
    endtask

    task automatic run_full_width(input int unsigned count);
        logic [CAND_WIDTH-1:0] n;
        int unsigned           divisions;
        bit                    verdict;
        repeat (count)
        begin
            n = $urandom();
            verdict = trial_divide(n, divisions);
            // keep the run short: a costly word is made even
            if (verdict || divisions > WIDE_DIV_BUDGET)
                n[0] = 1'b0;
            send_candidate(n);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        candidate   = '0;
        out_ready   = 1'b0;
        no_gaps     = 1'b0;
        error_count = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        run_directed_edges();
        run_steady_stream(30);
        run_gapped_small(25);
        run_medium_numbers(15);
        run_full_width(30);

        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("trial_division_prime_test verification clean");
        else
            $display("trial_division_prime_test verification failed");
        $finish;
    end

    // The largest 32-bit prime is the slowest run; the timeout allows several
    // times the whole run.
    initial
    begin
        #60_000_000;
        $display("trial_division_prime_test verification failed");
        $finish;
    end

endmodule

[sim.f]
rtl/tdp_pkg.sv
rtl/tdp_divider.sv
rtl/trial_division_prime_test.sv
tb/trial_division_prime_test_tb.sv
